>>> hw/rtl/rgd_pkg.sv
// Shared types and constants of the refined-grid diffusion stencil.
package rgd_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 4096;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);

  // Register field widths.
  localparam int CFG_ROWS_W  = 13;
  localparam int CFG_COLS_W  = 11;
  localparam int CFG_W_W     = 17;
  localparam int CFG_S_W     = 24;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_IDX_W   = 2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIFFUSION_WEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REACTION_SCALE   = 2'd3;

  typedef struct packed {
    logic signed [31:0] cell_value;
    logic               grid_start;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_value;
    logic [11:0]        row_index;
    logic [9:0]         col_index;
    logic               last_cell;
    logic               saturated;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic shift;
    logic mul1;
    logic mul2;
    logic mul3;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic produce;
  } dp_status_t;

endpackage

>>> hw/rtl/refined_grid_diffusion_stencil.sv
// Top level of the refined-grid diffusion stencil.
// Grid cells arrive in raster order on the in_ channel, one request at a time;
// once a cell at row and column 2 or more arrives, the interior cell one row and
// one column behind it yields one saturated Q16.16 result on the out_ channel;
// boundary cells yield none. A boundary cell goes through the line buffer read
// and the window shift. An interior cell reaches the result register through
// the window shift, the three registered multiplier stages behind the window
// (scale squared, weight products, reaction product) and the final sum; the next
// cell is taken in the cycle after the result is loaded, while that result may
// still wait in the output register. If the output register is still full the
// block holds its result until it is taken. Configuration writes take effect
// at once and are to be made between requests.
module refined_grid_diffusion_stencil (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rgd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rgd_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rgd_pkg::out_item_t             out_data
);

  rgd_pkg::dp_cmd_t    cmd;
  rgd_pkg::dp_status_t status;

  rgd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  rgd_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

>>> hw/rtl/rgd_ctrl.sv
// Controller state machine: sequences one request through the datapath.
module rgd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  rgd_pkg::dp_status_t status,
  output rgd_pkg::dp_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WIN  = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_MUL3 = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    cmd.accept   = (state_r == S_IDLE) && in_valid;
    cmd.shift    = (state_r == S_WIN);
    cmd.mul1     = (state_r == S_MUL1);
    cmd.mul2     = (state_r == S_MUL2);
    cmd.mul3     = (state_r == S_MUL3);
    cmd.load_out = (state_r == S_DONE) && out_free;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_WIN;
      end
      S_WIN: begin
        // boundary cells end here with no result
        state_nxt = status.produce ? S_MUL1 : S_IDLE;
      end
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_MUL3;
      S_MUL3: state_nxt = S_DONE;
      S_DONE: begin
        // hold until the output register is free
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hw/rtl/rgd_datapath.sv
// Datapath: registers, position tracking, line buffers, window and arithmetic.
module rgd_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rgd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rgd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  rgd_pkg::in_item_t                   in_data,
  input  rgd_pkg::dp_cmd_t                    cmd,
  output rgd_pkg::dp_status_t                 status,
  output rgd_pkg::out_item_t                  out_data
);

  localparam int RW = rgd_pkg::ROW_W;
  localparam int CW = rgd_pkg::COL_W;
  localparam int RCW = rgd_pkg::CFG_ROWS_W;
  localparam int CCW = rgd_pkg::CFG_COLS_W;

  // configuration
  logic [RCW-1:0]                   row_count_r;
  logic [CCW-1:0]                   col_count_r;
  logic [rgd_pkg::CFG_W_W-1:0]      weight_r;
  logic signed [rgd_pkg::CFG_S_W-1:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= RCW'(3);
      col_count_r <= CCW'(3);
      weight_r    <= '0;
      scale_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rgd_pkg::REG_ROW_COUNT:        row_count_r <= cfg_wdata[RCW-1:0];
        rgd_pkg::REG_COL_COUNT:        col_count_r <= cfg_wdata[CCW-1:0];
        rgd_pkg::REG_DIFFUSION_WEIGHT: weight_r    <= cfg_wdata[rgd_pkg::CFG_W_W-1:0];
        rgd_pkg::REG_REACTION_SCALE:   scale_r     <= $signed(cfg_wdata[rgd_pkg::CFG_S_W-1:0]);
      endcase
    end
  end

  // effective grid size, clamped
  logic [RCW-1:0] eff_rows;
  logic [CCW-1:0] eff_cols;

  always_comb begin
    eff_rows = row_count_r;
    if (row_count_r < RCW'(3)) eff_rows = RCW'(3);
    else if (row_count_r > RCW'(rgd_pkg::MAX_ROWS)) eff_rows = RCW'(rgd_pkg::MAX_ROWS);
    eff_cols = col_count_r;
    if (col_count_r < CCW'(3)) eff_cols = CCW'(3);
    else if (col_count_r > CCW'(rgd_pkg::MAX_COLS)) eff_cols = CCW'(rgd_pkg::MAX_COLS);
  end

  // position of the incoming cell
  logic [RW-1:0]  row_pos_r, row_pos_nxt;
  logic [CW-1:0]  col_pos_r, col_pos_nxt;
  logic [RW-1:0]  r0, r_cur;
  logic [CW-1:0]  c0, c_cur;
  logic [RW:0]    r1, r_inc;
  logic [CW:0]    c_inc;
  logic           col_wrap;
  logic           is_last_col;

  always_comb begin
    r0       = in_data.grid_start ? '0 : row_pos_r;
    c0       = in_data.grid_start ? '0 : col_pos_r;
    // sizes may have shrunk under a stored position
    col_wrap = ({1'b0, c0} >= eff_cols);
    c_cur    = col_wrap ? '0 : c0;
    r1       = {1'b0, r0} + (RW+1)'(col_wrap);
    r_cur    = (r1 >= eff_rows) ? '0 : r1[RW-1:0];
    c_inc    = {1'b0, c_cur} + (CW+1)'(1);
    r_inc    = {1'b0, r_cur} + (RW+1)'(1);
    if (c_inc >= eff_cols) begin
      col_pos_nxt = '0;
      row_pos_nxt = (r_inc >= eff_rows) ? '0 : r_inc[RW-1:0];
    end else begin
      col_pos_nxt = c_inc[CW-1:0];
      row_pos_nxt = r_cur;
    end
    is_last_col = ({1'b0, c_cur} == eff_cols - CCW'(1));
  end

  // per-request flags, latched at accept
  logic           produce_r;
  logic           row_sub_r, col_sub_r, last_r, bank_r;
  logic [RW-1:0]  i_r;
  logic [CW-1:0]  j_r;
  logic signed [31:0] cell_r;
  logic [RW-1:0]  i_nxt;
  logic [CW-1:0]  j_nxt;

  assign i_nxt = r_cur - RW'(1);
  assign j_nxt = c_cur - CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r <= '0;
      col_pos_r <= '0;
      produce_r <= 1'b0;
    end else if (cmd.accept) begin
      row_pos_r <= row_pos_nxt;
      col_pos_r <= col_pos_nxt;
      produce_r <= (r_cur >= RW'(2)) && (c_cur >= CW'(2));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cell_r    <= in_data.cell_value;
      bank_r    <= r_cur[0];
      i_r       <= i_nxt;
      j_r       <= j_nxt;
      row_sub_r <= (i_nxt == RW'(1)) && (j_nxt[0] || is_last_col);
      col_sub_r <= is_last_col && i_nxt[0];
      last_r    <= ({1'b0, r_cur} == eff_rows - RCW'(1)) && is_last_col;
    end
  end

  assign status.produce = produce_r;

  // line buffers: bank b holds rows with row[0] == b
  logic [31:0] line0_mem [rgd_pkg::MAX_COLS];
  logic [31:0] line1_mem [rgd_pkg::MAX_COLS];
  logic [31:0] rd0_r, rd1_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd0_r <= line0_mem[c_cur];
      if (!r_cur[0]) line0_mem[c_cur] <= in_data.cell_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd1_r <= line1_mem[c_cur];
      if (r_cur[0]) line1_mem[c_cur] <= in_data.cell_value;
    end
  end

  // 3x3 window: row 0 top, column 2 newest
  logic signed [31:0] win_r [3][3];
  logic signed [31:0] top, mid;

  assign top = bank_r ? $signed(rd1_r) : $signed(rd0_r);
  assign mid = bank_r ? $signed(rd0_r) : $signed(rd1_r);

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= top;
      win_r[1][2] <= mid;
      win_r[2][2] <= cell_r;
    end
  end

  // second differences, kept doubled
  logic signed [36:0] ul, up, ur, lf, ctr_e, rt, dn, dr;
  logic signed [36:0] vert2, horz2, dsum_nxt;
  logic signed [31:0] ctr;

  always_comb begin
    ul    = 37'(win_r[0][0]);
    up    = 37'(win_r[0][1]);
    ur    = 37'(win_r[0][2]);
    lf    = 37'(win_r[1][0]);
    ctr   = win_r[1][1];
    ctr_e = 37'(win_r[1][1]);
    rt    = 37'(win_r[1][2]);
    dn    = 37'(win_r[2][1]);
    dr    = 37'(win_r[2][2]);
    vert2 = (row_sub_r ? (ul + ur) : (up <<< 1)) - (ctr_e <<< 2) + (dn <<< 1);
    horz2 = (col_sub_r ? (dr + ur) : (rt <<< 1)) - (ctr_e <<< 2) + (lf <<< 1);
    dsum_nxt = vert2 + horz2;
  end

  // stage 1: S*S rounded to Q.16
  logic signed [47:0] ss, ss_rnd;
  logic [30:0]        sq_r;
  logic signed [36:0] dsum_r;

  assign ss     = scale_r * scale_r;
  assign ss_rnd = ss + 48'sd32768;

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      sq_r   <= ss_rnd[46:16];
      dsum_r <= dsum_nxt;
    end
  end

  // stage 2: R = W*q, and W times the difference sum in two halves
  logic [47:0]        wq, wq_rnd;
  logic [34:0]        dlo, dlo_r;
  logic signed [36:0] dhi, dhi_r;
  logic [30:0]        rq_r;

  assign wq     = weight_r * sq_r;
  assign wq_rnd = wq + 48'd32768;
  assign dlo    = weight_r * dsum_r[17:0];
  assign dhi    = $signed({1'b0, weight_r}) * $signed(dsum_r[36:18]);

  always_ff @(posedge clk) begin
    if (cmd.mul2) begin
      rq_r  <= wq_rnd[46:16];
      dlo_r <= dlo;
      dhi_r <= dhi;
    end
  end

  // stage 3: reaction product and diffusion term, both rounded
  logic signed [63:0] rc, rc_rnd;
  logic signed [54:0] wd, wd_rnd;
  logic signed [47:0] react_r;
  logic signed [37:0] diff_r;

  assign rc     = $signed({1'b0, rq_r}) * ctr;
  assign rc_rnd = rc + 64'sd32768;
  assign wd     = (55'(dhi_r) <<< 18) + $signed({20'd0, dlo_r});
  assign wd_rnd = wd + 55'sd65536;

  always_ff @(posedge clk) begin
    if (cmd.mul3) begin
      react_r <= rc_rnd[63:16];
      diff_r  <= wd_rnd[54:17];
    end
  end

  // final sum and saturation
  logic signed [49:0] total;
  logic               sat;
  logic signed [31:0] clipped;
  rgd_pkg::out_item_t out_data_r;

  always_comb begin
    total   = 50'(ctr) + 50'(react_r) + 50'(diff_r);
    sat     = !((&total[49:31]) || (~|total[49:31]));
    clipped = sat ? (total[49] ? 32'sh80000000 : 32'sh7FFFFFFF) : total[31:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.new_value <= clipped;
      out_data_r.row_index <= i_r;
      out_data_r.col_index <= j_r;
      out_data_r.last_cell <= last_r;
      out_data_r.saturated <= sat;
    end
  end

  assign out_data = out_data_r;

endmodule

>>> hw/rtl/rgd_checker.sv
// Port-level checker for the stencil, bound to the top level.
module rgd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           cfg_we,
  input logic [rgd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [rgd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input logic                           in_valid,
  input logic                           in_stall,
  input rgd_pkg::in_item_t              in_data,
  input logic                           out_valid,
  input logic                           out_stall,
  input rgd_pkg::out_item_t             out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one request at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request accepted back to back");

  // a new result is loaded only while a request is in work
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no request in work");

  // only interior cells produce results
  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.row_index != 12'd0) && (out_data.col_index != 10'd0))
    else $error("result for a boundary cell");

  // a clipped result sits at a range limit
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      (out_data.new_value == 32'sh7FFFFFFF) || (out_data.new_value == 32'sh80000000))
    else $error("saturated flag with unclipped value");

endmodule

bind refined_grid_diffusion_stencil rgd_checker u_rgd_checker (.*);

>>> bench/tb_refined_grid_diffusion_stencil.sv
// Testbench for the refined-grid diffusion stencil: directed table, random grids, self-checking.
module tb_refined_grid_diffusion_stencil;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint LIMIT_NS    = 20_000_000;
  localparam int     SETTLE      = 12;
  localparam int     PHASE_CELLS = 330;
  localparam int     CLAMP_CELLS = 200;
  localparam longint Q_MAX       = 64'sd2147483647;
  localparam longint Q_MIN       = -64'sd2147483648;

  typedef enum logic {ST_CELL, ST_CFG} step_kind_t;

  typedef struct {
    step_kind_t                    kind;
    logic [rgd_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                   value;
    logic                          start;
    bit                            fixed;
    rgd_pkg::out_item_t            want;
  } dir_step_t;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           cfg_we    = 1'b0;
  logic [rgd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rgd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  rgd_pkg::in_item_t              in_data   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  rgd_pkg::out_item_t             out_data;

  refined_grid_diffusion_stencil u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Stencil shadow: registers, line banks, window and raster position.
  logic [rgd_pkg::CFG_ROWS_W-1:0] rows_reg   = 13'd3;
  logic [rgd_pkg::CFG_COLS_W-1:0] cols_reg   = 11'd3;
  logic [rgd_pkg::CFG_W_W-1:0]    weight_reg = '0;
  logic [rgd_pkg::CFG_S_W-1:0]    scale_reg  = '0;
  logic [31:0]                    line_mem [2*rgd_pkg::MAX_COLS];
  logic signed [31:0]             win [3][3];
  int unsigned                    next_row = 0;
  int unsigned                    next_col = 0;

  rgd_pkg::out_item_t pending_cells [$];
  dir_step_t dir_tab [$];
  int        mismatch_count = 0;
  int        idle_pct       = 0;
  int        stall_pct      = 0;
  int        hold_left      = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint round_q(longint x, int k);
    return (x + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  // Advance the shadow by one cell; return 1 with the new interior value when one is due.
  function automatic bit diffuse_cell(rgd_pkg::in_item_t it, output rgd_pkg::out_item_t res);
    int unsigned rc, cc, r, c, i, j, k;
    longint ul, up, ur, lf, ctr, rt, dn, dr;
    longint vert2, horz2, wt, sc, sq, rq, react, diff, sum;
    bit row_sub, col_sub, sat;
    rc = clamp_size(rows_reg, rgd_pkg::MAX_ROWS);
    cc = clamp_size(cols_reg, rgd_pkg::MAX_COLS);
    res = '0;
    if (it.grid_start) begin
      next_row = 0;
      next_col = 0;
    end
    if (next_col >= cc) begin
      next_col = 0;
      next_row++;
    end
    if (next_row >= rc) next_row = 0;
    r = next_row;
    c = next_col;
    for (k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = line_mem[(r & 1) * rgd_pkg::MAX_COLS + c];
    win[1][2] = line_mem[((r + 1) & 1) * rgd_pkg::MAX_COLS + c];
    win[2][2] = it.cell_value;
    line_mem[(r & 1) * rgd_pkg::MAX_COLS + c] = it.cell_value;
    next_col = c + 1;
    if (next_col >= cc) begin
      next_col = 0;
      next_row = r + 1;
      if (next_row >= rc) next_row = 0;
    end
    if (r < 2 || c < 2) return 1'b0;

    i = r - 1;
    j = c - 1;
    ul = win[0][0]; up = win[0][1]; ur = win[0][2];
    lf = win[1][0]; ctr = win[1][1]; rt = win[1][2];
    dn = win[2][1]; dr = win[2][2];
    // interface neighbours become the mean of two diagonals, kept doubled
    row_sub = (i == 1) && ((j % 2 == 1) || (j == cc - 2));
    col_sub = (j == cc - 2) && (i % 2 == 1);
    vert2 = (row_sub ? ul + ur : 2 * up) - 4 * ctr + 2 * dn;
    horz2 = (col_sub ? dr + ur : 2 * rt) - 4 * ctr + 2 * lf;
    wt = longint'(weight_reg);
    sc = longint'(signed'(scale_reg));
    sq = round_q(sc * sc, 16);
    rq = round_q(wt * sq, 16);
    react = round_q(rq * ctr, 16);
    diff = round_q(wt * (vert2 + horz2), 17);
    sum = ctr + react + diff;
    sat = 1'b0;
    if (sum > Q_MAX) begin
      sum = Q_MAX;
      sat = 1'b1;
    end
    if (sum < Q_MIN) begin
      sum = Q_MIN;
      sat = 1'b1;
    end
    res.new_value = sum[31:0];
    res.row_index = i[11:0];
    res.col_index = j[9:0];
    res.last_cell = (r == rc - 1) && (c == cc - 1);
    res.saturated = sat;
    return 1'b1;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    mismatch_count++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
  endtask

  // Offer one cell request; the caller is at a falling edge.
  task automatic send_cell(logic [31:0] value, logic start, bit fixed,
                           rgd_pkg::out_item_t want);
    rgd_pkg::in_item_t  it;
    rgd_pkg::out_item_t res;
    it.cell_value = value;
    it.grid_start = start;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (diffuse_cell(it, res)) pending_cells.push_back(fixed ? want : res);
    @(negedge clk);
  endtask

  // Drop the request line, let every pending result out, then let the pipe settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [rgd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    in_valid  <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[rgd_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    case (idx)
      rgd_pkg::REG_ROW_COUNT:        rows_reg   = val[rgd_pkg::CFG_ROWS_W-1:0];
      rgd_pkg::REG_COL_COUNT:        cols_reg   = val[rgd_pkg::CFG_COLS_W-1:0];
      rgd_pkg::REG_DIFFUSION_WEIGHT: weight_reg = val[rgd_pkg::CFG_W_W-1:0];
      rgd_pkg::REG_REACTION_SCALE:   scale_reg  = val[rgd_pkg::CFG_S_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic pick_config();
    logic [31:0] rows_v, cols_v, w_v, s_v;
    rows_v = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(7, 3);
    cols_v = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(12, 3);
    case ($urandom_range(4))
      0:       w_v = 0;
      1:       w_v = 131071;
      default: w_v = $urandom_range(131071);
    endcase
    case ($urandom_range(5))
      0:       s_v = 0;
      1:       s_v = 32'h007F_FFFF;
      2:       s_v = 32'h0080_0000;
      3:       s_v = $urandom();
      default: s_v = $urandom_range(131072) - 65536;
    endcase
    write_reg(rgd_pkg::REG_ROW_COUNT, rows_v);
    write_reg(rgd_pkg::REG_COL_COUNT, cols_v);
    write_reg(rgd_pkg::REG_DIFFUSION_WEIGHT, w_v);
    write_reg(rgd_pkg::REG_REACTION_SCALE, s_v);
  endtask

  function automatic logic [31:0] pick_cell();
    logic [31:0] raw;
    raw = $urandom();
    case ($urandom_range(5))
      0, 1:    return raw;
      2, 3, 4: return {{8{raw[23]}}, raw[23:0]};
      default: return ($urandom_range(1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  // One grid in raster order; may be cut short, with a stray grid_start now and then.
  task automatic run_grid(input bit fresh, input bit may_cut, output int unsigned count);
    int unsigned n;
    bit st;
    n = clamp_size(rows_reg, rgd_pkg::MAX_ROWS) * clamp_size(cols_reg, rgd_pkg::MAX_COLS);
    count = (may_cut && $urandom_range(9) == 0) ? $urandom_range(n - 1, 1) : n;
    for (int unsigned k = 0; k < count; k++) begin
      st = (k == 0) ? (fresh || $urandom_range(3) != 0) : ($urandom_range(99) == 0);
      send_cell(pick_cell(), st, 1'b0, '0);
    end
  endtask

  function automatic dir_step_t cell_step(logic [31:0] v, logic s);
    dir_step_t d;
    d = '{kind: ST_CELL, index: '0, value: v, start: s, fixed: 1'b0, want: '0};
    return d;
  endfunction

  function automatic dir_step_t cell_fixed(logic [31:0] v, logic s, rgd_pkg::out_item_t w);
    dir_step_t d;
    d = '{kind: ST_CELL, index: '0, value: v, start: s, fixed: 1'b1, want: w};
    return d;
  endfunction

  function automatic dir_step_t reg_step(logic [rgd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
    dir_step_t d;
    d = '{kind: ST_CFG, index: idx, value: v, start: 1'b0, fixed: 1'b0, want: '0};
    return d;
  endfunction

  // Receiver: random stall, or a counted hold-off when one is requested.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_out
    rgd_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cells.size() == 0) begin
        flag_mismatch("unexpected result", out_data.new_value, 0);
      end else begin
        want = pending_cells.pop_front();
        if (out_data.new_value !== want.new_value)
          flag_mismatch("new_value", out_data.new_value, want.new_value);
        if (out_data.row_index !== want.row_index)
          flag_mismatch("row_index", out_data.row_index, want.row_index);
        if (out_data.col_index !== want.col_index)
          flag_mismatch("col_index", out_data.col_index, want.col_index);
        if (out_data.last_cell !== want.last_cell)
          flag_mismatch("last_cell", out_data.last_cell, want.last_cell);
        if (out_data.saturated !== want.saturated)
          flag_mismatch("saturated", out_data.saturated, want.saturated);
      end
    end
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("FAIL refined_grid_diffusion_stencil");
    $finish;
  end

  initial begin : main
    int unsigned sent, got;
    bit fresh;
    int ph;

    // 3x3 after reset, no weight: the interior cell passes through unchanged
    dir_tab.push_back(cell_step(32'h7FFF_FFFF, 1'b1));
    dir_tab.push_back(cell_step(32'h8000_0000, 1'b0));
    dir_tab.push_back(cell_step(32'h0000_0000, 1'b0));
    dir_tab.push_back(cell_step(32'h8000_0000, 1'b0));
    dir_tab.push_back(cell_step(32'h8000_0000, 1'b0));
    dir_tab.push_back(cell_step(32'h7FFF_FFFF, 1'b0));
    dir_tab.push_back(cell_step(32'h0000_0000, 1'b0));
    dir_tab.push_back(cell_step(32'h7FFF_FFFF, 1'b0));
    dir_tab.push_back(cell_fixed(32'h7FFF_FFFF, 1'b0,
        '{new_value: 32'h8000_0000, row_index: 12'd1, col_index: 10'd1,
          last_cell: 1'b1, saturated: 1'b0}));
    // too few rows, extreme weight and scale; next grid follows the wrap, no grid_start
    dir_tab.push_back(reg_step(rgd_pkg::REG_ROW_COUNT, 32'd1));
    dir_tab.push_back(reg_step(rgd_pkg::REG_COL_COUNT, 32'd5));
    dir_tab.push_back(reg_step(rgd_pkg::REG_DIFFUSION_WEIGHT, 32'd131071));
    dir_tab.push_back(reg_step(rgd_pkg::REG_REACTION_SCALE, 32'h0080_0000));
    for (int rr = 0; rr < 2; rr++) begin
      dir_tab.push_back(cell_step(32'h7FFF_FFFF, 1'b0));
      dir_tab.push_back(cell_step(32'h7FFF_FFFF, 1'b0));
      dir_tab.push_back(cell_step(32'h7FFF_FFFF, 1'b0));
      dir_tab.push_back(cell_step(32'h8000_0000, 1'b0));
      dir_tab.push_back(cell_step((rr == 0) ? 32'h0001_0000 : 32'hFFFF_0000, 1'b0));
    end
    dir_tab.push_back(cell_step(32'h7FFF_FFFF, 1'b0));
    dir_tab.push_back(cell_step(32'h7FFF_FFFF, 1'b0));
    dir_tab.push_back(cell_fixed(32'h7FFF_FFFF, 1'b0,
        '{new_value: 32'h7FFF_FFFF, row_index: 12'd1, col_index: 10'd1,
          last_cell: 1'b0, saturated: 1'b1}));
    // narrow the grid mid row: the next cell is the top-right corner, both substitutions
    dir_tab.push_back(reg_step(rgd_pkg::REG_COL_COUNT, 32'd4));
    dir_tab.push_back(cell_step(32'h8000_0000, 1'b0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[n]) begin
      if (dir_tab[n].kind == ST_CFG) begin
        wait_idle();
        write_reg(dir_tab[n].index, dir_tab[n].value);
      end else begin
        send_cell(dir_tab[n].value, dir_tab[n].start, dir_tab[n].fixed, dir_tab[n].want);
      end
    end

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 62; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      sent = 0;
      while (sent < PHASE_CELLS) begin
        fresh = 1'b0;
        if ($urandom_range(1) == 0) begin
          wait_idle();
          pick_config();
          fresh = 1'b1;
        end
        // hold the receiver off so the block fills and stalls its input
        if (sent == 0 && (ph == 0 || ph == 2)) hold_left = 400;
        run_grid(fresh, 1'b1, got);
        sent += got;
        // pause the sender until every pending result is out
        if (ph == 1 && $urandom_range(3) == 0) wait_idle();
      end
    end

    // oversized registers: a short run into grids at the largest sides
    idle_pct  = 0;
    stall_pct = 0;
    wait_idle();
    write_reg(rgd_pkg::REG_ROW_COUNT, 32'd8191);
    write_reg(rgd_pkg::REG_COL_COUNT, 32'd3);
    write_reg(rgd_pkg::REG_DIFFUSION_WEIGHT, $urandom_range(131071));
    write_reg(rgd_pkg::REG_REACTION_SCALE, $urandom_range(131072) - 65536);
    for (int k = 0; k < CLAMP_CELLS; k++) send_cell(pick_cell(), (k == 0), 1'b0, '0);
    wait_idle();
    write_reg(rgd_pkg::REG_ROW_COUNT, 32'd3);
    write_reg(rgd_pkg::REG_COL_COUNT, 32'd2047);
    for (int k = 0; k < CLAMP_CELLS; k++) send_cell(pick_cell(), (k == 0), 1'b0, '0);

    wait_idle();
    if (mismatch_count == 0 && pending_cells.size() == 0) begin
      $display("PASS refined_grid_diffusion_stencil");
    end else begin
      $display("FAIL refined_grid_diffusion_stencil");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/rgd_pkg.sv
hw/rtl/rgd_ctrl.sv
hw/rtl/rgd_datapath.sv
hw/rtl/refined_grid_diffusion_stencil.sv
hw/rtl/rgd_checker.sv
bench/tb_refined_grid_diffusion_stencil.sv
